[rtl/core/crtp_pkg.sv]
// ----------------------------------------------------------------------------
// crtp_pkg
// Shared types, codes and keyword tables of the crawler rules text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package crtp_pkg;

	localparam int MAX_AGENT_LEN_DEF = 16;
	localparam int NAME_BYTES = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int LEN_W = 5;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH = 2'd2;

	// Character codes
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		KW_AGENT    = 3'd0,
		KW_DISALLOW = 3'd1,
		KW_ALLOW    = 3'd2,
		KW_SITEMAP  = 3'd3,
		KW_DELAY    = 3'd4
	} kw_t;

	typedef enum logic [1:0] {
		KIND_DISALLOW = 2'd0,
		KIND_ALLOW    = 2'd1,
		KIND_DELAY    = 2'd2
	} kind_t;

	typedef enum logic [5:0] {
		PH_LINE_START = 6'b000001,
		PH_KEYWORD    = 6'b000010,
		PH_SKIP_LINE  = 6'b000100,
		PH_PARAM_WS   = 6'b001000,
		PH_AGENT      = 6'b010000,
		PH_VALUE      = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [8*NAME_BYTES-1:0] name;
		logic [LEN_W-1:0]        length;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
		logic       byte_valid;
		logic       value_end;
	} result_t;

	function automatic logic [7:0] to_lower(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5a]}) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [3:0] kw_len(kw_t k);
		logic [3:0] n;
		case (k)
			KW_AGENT: n = 4'd11;
			KW_DISALLOW: n = 4'd9;
			KW_ALLOW: n = 4'd6;
			KW_SITEMAP: n = 4'd8;
			KW_DELAY: n = 4'd12;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Lower-case keyword text, left aligned in twelve characters.
	function automatic logic [7:0] kw_char(kw_t k, logic [3:0] pos);
		logic [95:0] s;
		logic [7:0]  c;
		int          idx;
		case (k)
			KW_AGENT: s = "user-agent: ";
			KW_DISALLOW: s = "disallow:   ";
			KW_ALLOW: s = "allow:      ";
			KW_SITEMAP: s = "sitemap:    ";
			KW_DELAY: s = "crawl-delay:";
			default: s = '0;
		endcase
		idx = 11 - int'(pos);
		c = 8'h00;
		if (pos < 4'd12) begin
			c = s[8*idx +: 8];
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/crtp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// crtp_cfg_regs
// Write-only register file that holds the crawler agent name and its length.
// ----------------------------------------------------------------------------
`default_nettype none

module crtp_cfg_regs
	import crtp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                        cfg
);

	logic [CFG_DATA_W-1:0] name_low_q;
	logic [CFG_DATA_W-1:0] name_high_q;
	logic [LEN_W-1:0]      name_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q <= '0;
			name_high_q <= '0;
			name_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NAME_LOW: name_low_q <= cfg_wdata;
				REG_NAME_HIGH: name_high_q <= cfg_wdata;
				REG_NAME_LENGTH: name_length_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.name = {name_high_q, name_low_q};
	assign cfg.length = name_length_q;

endmodule

`default_nettype wire

[rtl/core/crtp_parser.sv]
// ----------------------------------------------------------------------------
// crtp_parser
// Line phase, keyword and agent state, updated once for every text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crtp_parser
	import crtp_pkg::*;
#(
	parameter int MAX_AGENT_LEN = MAX_AGENT_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_take,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eot,
	output result_t         res
);

	localparam int AP_W = $clog2(MAX_AGENT_LEN + 1);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_AGENT_LEN);

	phase_t          phase_q, phase_n;
	kw_t             cand_q, cand_n;
	logic [3:0]      kpos_q, kpos_n;
	logic            accept_q, accept_n;
	logic [AP_W-1:0] apos_q, apos_n;
	logic            amatch_q, amatch_n;
	logic            astar_q, astar_n;

	logic [AP_W-1:0] name_len;
	logic [7:0]      lc;
	logic [7:0]      name_ch;
	logic            streamed;
	logic            open_line;
	logic            blank;
	kind_t           kind;

	assign name_len = (cfg.length > MAX_LEN) ? AP_W'(MAX_AGENT_LEN) : AP_W'(cfg.length);
	assign lc = to_lower(in_byte);
	assign name_ch = to_lower(cfg.name[8*4'(apos_q) +: 8]);
	assign streamed = (cand_q == KW_DELAY) ||
		(((cand_q == KW_DISALLOW) || (cand_q == KW_ALLOW)) && accept_q);
	assign open_line = (phase_q == PH_PARAM_WS) || (phase_q == PH_AGENT) ||
		(phase_q == PH_VALUE);
	assign blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

	always_comb begin
		case (cand_q)
			KW_DISALLOW: kind = KIND_DISALLOW;
			KW_ALLOW: kind = KIND_ALLOW;
			default: kind = KIND_DELAY;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		cand_n = cand_q;
		kpos_n = kpos_q;
		accept_n = accept_q;
		apos_n = apos_q;
		amatch_n = amatch_q;
		astar_n = astar_q;
		res.valid = 1'b0;
		res.kind = kind;
		res.data = 8'h00;
		res.byte_valid = 1'b0;
		res.value_end = 1'b0;

		if (in_eot || (in_byte == CH_NUL) || (in_byte == CH_CR) || (in_byte == CH_LF) ||
			((in_byte == CH_HASH) && (phase_q != PH_KEYWORD))) begin
			// Closing a line with a complete keyword.
			if (open_line) begin
				if (cand_q == KW_AGENT) begin
					accept_n = astar_q || (amatch_q && (apos_q >= name_len));
				end else if (streamed) begin
					res.valid = 1'b1;
					res.value_end = 1'b1;
				end
			end
			if (in_eot || (in_byte == CH_NUL)) begin
				phase_n = PH_LINE_START;
				cand_n = KW_AGENT;
				kpos_n = '0;
				accept_n = 1'b1;
				apos_n = '0;
				amatch_n = 1'b1;
				astar_n = 1'b0;
			end else if (in_byte == CH_HASH) begin
				phase_n = PH_SKIP_LINE;
			end else begin
				phase_n = PH_LINE_START;
			end
		end else begin
			case (phase_q)
				PH_LINE_START: begin
					if (!blank) begin
						phase_n = PH_SKIP_LINE;
						kpos_n = 4'd1;
						if (lc == kw_char(KW_AGENT, 4'd0)) begin
							cand_n = KW_AGENT;
							phase_n = PH_KEYWORD;
						end else if (lc == kw_char(KW_DISALLOW, 4'd0)) begin
							cand_n = KW_DISALLOW;
							phase_n = PH_KEYWORD;
						end else if (lc == kw_char(KW_ALLOW, 4'd0)) begin
							cand_n = KW_ALLOW;
							phase_n = PH_KEYWORD;
						end else if (lc == kw_char(KW_SITEMAP, 4'd0)) begin
							cand_n = KW_SITEMAP;
							phase_n = PH_KEYWORD;
						end else if (lc == kw_char(KW_DELAY, 4'd0)) begin
							cand_n = KW_DELAY;
							phase_n = PH_KEYWORD;
						end else begin
							kpos_n = kpos_q;
						end
					end
				end
				PH_KEYWORD: begin
					if ((kpos_q >= kw_len(cand_q)) || (lc != kw_char(cand_q, kpos_q))) begin
						phase_n = PH_SKIP_LINE;
					end else begin
						kpos_n = kpos_q + 4'd1;
						if ((kpos_q + 4'd1) == kw_len(cand_q)) begin
							if (cand_q == KW_SITEMAP) begin
								phase_n = PH_SKIP_LINE;
							end else begin
								phase_n = PH_PARAM_WS;
								apos_n = '0;
								amatch_n = 1'b1;
								astar_n = 1'b0;
							end
						end
					end
				end
				PH_PARAM_WS: begin
					if (!blank) begin
						if (cand_q == KW_AGENT) begin
							astar_n = (in_byte == CH_STAR);
							phase_n = PH_AGENT;
							if (apos_q < name_len) begin
								amatch_n = amatch_q && (lc == name_ch);
								apos_n = apos_q + AP_W'(1);
							end
						end else begin
							phase_n = PH_VALUE;
							res.valid = streamed;
							res.data = in_byte;
							res.byte_valid = 1'b1;
						end
					end
				end
				PH_AGENT: begin
					if (apos_q < name_len) begin
						amatch_n = amatch_q && (lc == name_ch);
						apos_n = apos_q + AP_W'(1);
					end
				end
				PH_VALUE: begin
					res.valid = streamed;
					res.data = in_byte;
					res.byte_valid = 1'b1;
				end
				default: ;
			endcase
		end
		res.valid = res.valid && in_take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START;
			cand_q <= KW_AGENT;
			kpos_q <= '0;
			accept_q <= 1'b1;
			apos_q <= '0;
			amatch_q <= 1'b1;
			astar_q <= 1'b0;
		end else if (in_take) begin
			phase_q <= phase_n;
			cand_q <= cand_n;
			kpos_q <= kpos_n;
			accept_q <= accept_n;
			apos_q <= apos_n;
			amatch_q <= amatch_n;
			astar_q <= astar_n;
		end
	end

endmodule

`default_nettype wire

[rtl/core/crtp_out_buf.sv]
// ----------------------------------------------------------------------------
// crtp_out_buf
// Result register with one skid entry between parser and output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module crtp_out_buf
	import crtp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire result_t push,
	output logic         space,
	output result_t      head,
	input  wire logic    pop_ready
);

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign pop = out_valid_q && pop_ready;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			// The skid entry is older than any new result, so it moves up first.
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push.valid;
			end
		end else if (push.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push;
		end else if (push.valid) begin
			skid_q <= push;
		end
	end

	always_comb begin
		head = out_q;
		head.valid = out_valid_q;
	end

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push.valid)
		else $error("result pushed while both entries are full");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry lost on transfer");

	a_end_has_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.value_end && out_q.byte_valid))
		else $error("end marker carries a value byte");

endmodule

`default_nettype wire

[rtl/core/crawler_rules_text_parser_core.sv]
// ----------------------------------------------------------------------------
// crawler_rules_text_parser_core
// Streams rule and crawl-delay value bytes out of a robots rules text.
// ----------------------------------------------------------------------------
// A result is registered in the output buffer, in its skid entry first when the
// result register is stalled. Throughput: one text byte per cycle, set by the
// per-byte update of the line phase and keyword registers; a two-entry result
// buffer drives s_tready from a register and holds the input only once both
// entries are full. Reset clears the parser to line start with the group
// accepted, and clears the agent name registers to zero.
`default_nettype none

module crawler_rules_text_parser_core
	import crtp_pkg::*;
#(
	parameter int MAX_AGENT_LEN = MAX_AGENT_LEN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,   // text_byte
	input  wire logic                   s_tlast,   // end_of_text
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [15:0]                 m_tdata,   // value_byte, byte_valid, zero fill
	output logic [1:0]                  m_tuser,   // value_kind
	output logic                        m_tlast,   // value_end
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t    cfg;
	result_t res;
	result_t head;
	logic    space;
	logic    take;

	assign s_tready = space;
	assign take = s_tvalid && space;

	crtp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	crtp_parser #(
		.MAX_AGENT_LEN (MAX_AGENT_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_take (take),
		.in_byte (s_tdata),
		.in_eot  (s_tlast),
		.res     (res)
	);

	crtp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.space     (space),
		.head      (head),
		.pop_ready (m_tready)
	);

	assign m_tvalid = head.valid;
	assign m_tdata = {7'd0, head.byte_valid, head.data};
	assign m_tuser = head.kind;
	assign m_tlast = head.value_end;

endmodule

`default_nettype wire

[test/crawler_rules_text_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crawler_rules_text_parser_checker
// Watches the text, result and register ports of the rules text parser. It
// keeps its own line parser, predicts every value transfer, and compares the
// block's results against them in order.
// ----------------------------------------------------------------------------

module crawler_rules_text_parser_checker
	import crtp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [7:0]             s_tdata,   // text_byte
	input  wire logic                   s_tlast,   // end_of_text
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [15:0]            m_tdata,   // value_byte, byte_valid, zero fill
	input  wire logic [1:0]             m_tuser,   // value_kind
	input  wire logic                   m_tlast,   // value_end
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                          fail_count,
	output int                          outstanding
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       byte_valid;
		logic       value_end;
	} rule_value_t;

	rule_value_t rule_value_q[$];
	int          errors;

	// Register copies
	logic [63:0] name_lo;
	logic [63:0] name_hi;
	logic [4:0]  name_len_reg;

	// Parser state
	phase_t     line_phase;
	kw_t        rule_word;
	logic [3:0] word_pos;
	logic       group_on;
	logic [4:0] agent_idx;
	logic       agent_ok;
	logic       agent_wild;

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic string rule_word_text(kw_t k);
		case (k)
			KW_AGENT: return "user-agent:";
			KW_DISALLOW: return "disallow:";
			KW_ALLOW: return "allow:";
			KW_SITEMAP: return "sitemap:";
			default: return "crawl-delay:";
		endcase
	endfunction

	function automatic int used_name_len();
		return (name_len_reg > MAX_AGENT_LEN_DEF) ? MAX_AGENT_LEN_DEF : int'(name_len_reg);
	endfunction

	function automatic logic [7:0] name_char(int p);
		logic [127:0] name;
		name = {name_hi, name_lo};
		return name[8*p +: 8];
	endfunction

	function automatic logic value_is_streamed();
		if (rule_word == KW_DELAY) begin
			return 1'b1;
		end
		return (rule_word == KW_DISALLOW || rule_word == KW_ALLOW) && group_on;
	endfunction

	function automatic kind_t kind_of_rule();
		case (rule_word)
			KW_DISALLOW: return KIND_DISALLOW;
			KW_ALLOW: return KIND_ALLOW;
			default: return KIND_DELAY;
		endcase
	endfunction

	task automatic expect_value(input logic [7:0] c, input logic bv, input logic ve);
		rule_value_t v;
		v.kind = kind_of_rule();
		v.data = c;
		v.byte_valid = bv;
		v.value_end = ve;
		rule_value_q.insert(rule_value_q.size(), v);
	endtask

	task automatic compare_agent(input logic [7:0] c);
		if (agent_idx < used_name_len()) begin
			if (fold_case(c) != fold_case(name_char(agent_idx))) begin
				agent_ok = 1'b0;
			end
			agent_idx++;
		end
	endtask

	// Only a line whose keyword matched completely has anything to close.
	task automatic finish_line();
		if (line_phase == PH_PARAM_WS || line_phase == PH_AGENT || line_phase == PH_VALUE) begin
			if (rule_word == KW_AGENT) begin
				group_on = agent_wild || (agent_ok && agent_idx >= used_name_len());
			end else if (value_is_streamed()) begin
				expect_value(CH_NUL, 1'b0, 1'b1);
			end
		end
	endtask

	task automatic clear_parser();
		line_phase = PH_LINE_START;
		rule_word = KW_AGENT;
		word_pos = '0;
		group_on = 1'b1;
		agent_idx = '0;
		agent_ok = 1'b1;
		agent_wild = 1'b0;
	endtask

	task automatic parse_text_byte(input logic [7:0] c, input logic eot);
		string w;
		int    k;
		logic  hit;
		if (eot || c == CH_NUL) begin
			finish_line();
			clear_parser();
		end else if (c == CH_CR || c == CH_LF) begin
			finish_line();
			line_phase = PH_LINE_START;
		end else if (c == CH_HASH && line_phase != PH_KEYWORD) begin
			finish_line();
			line_phase = PH_SKIP_LINE;
		end else begin
			case (line_phase)
				PH_LINE_START: begin
					if (c != CH_SPACE && c != CH_TAB) begin
						line_phase = PH_SKIP_LINE;
						hit = 1'b0;
						for (k = 0; k < 5; k++) begin
							w = rule_word_text(kw_t'(k));
							if (!hit && fold_case(c) == w[0]) begin
								hit = 1'b1;
								rule_word = kw_t'(k);
								word_pos = 4'd1;
								line_phase = PH_KEYWORD;
							end
						end
					end
				end
				PH_KEYWORD: begin
					w = rule_word_text(rule_word);
					if (word_pos >= w.len() || fold_case(c) != w[word_pos]) begin
						line_phase = PH_SKIP_LINE;
					end else begin
						word_pos++;
						if (word_pos == w.len()) begin
							if (rule_word == KW_SITEMAP) begin
								line_phase = PH_SKIP_LINE;
							end else begin
								line_phase = PH_PARAM_WS;
								agent_idx = '0;
								agent_ok = 1'b1;
								agent_wild = 1'b0;
							end
						end
					end
				end
				PH_PARAM_WS: begin
					if (c != CH_SPACE && c != CH_TAB) begin
						if (rule_word == KW_AGENT) begin
							agent_wild = (c == CH_STAR);
							compare_agent(c);
							line_phase = PH_AGENT;
						end else begin
							line_phase = PH_VALUE;
							if (value_is_streamed()) begin
								expect_value(c, 1'b1, 1'b0);
							end
						end
					end
				end
				PH_AGENT: begin
					compare_agent(c);
				end
				PH_VALUE: begin
					if (value_is_streamed()) begin
						expect_value(c, 1'b1, 1'b0);
					end
				end
				default: begin
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rule_value_t want;
		if (!arst_n) begin
			name_lo = '0;
			name_hi = '0;
			name_len_reg = '0;
			clear_parser();
			rule_value_q.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NAME_LOW: name_lo = cfg_wdata;
					REG_NAME_HIGH: name_hi = cfg_wdata;
					REG_NAME_LENGTH: name_len_reg = cfg_wdata[LEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				parse_text_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (rule_value_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected transfer: kind %0d tdata %h last %b",
							m_tuser, m_tdata, m_tlast);
					end
				end else begin
					want = rule_value_q.pop_front();
					if (m_tuser !== want.kind || m_tdata !== {7'd0, want.byte_valid, want.data}
						|| m_tlast !== want.value_end) begin
						errors++;
						if (errors <= 10) begin
							$display({"value mismatch: expected kind %0d byte %h valid %b ",
								"end %b, got kind %0d byte %h valid %b end %b fill %h"},
								want.kind, want.data, want.byte_valid, want.value_end,
								m_tuser, m_tdata[7:0], m_tdata[8], m_tlast, m_tdata[15:9]);
						end
					end
				end
			end
			fail_count <= errors;
			outstanding <= rule_value_q.size();
		end
	end

endmodule

[test/crawler_rules_text_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crawler_rules_text_parser_core_tb
// Feeds rules texts into the parser core under several agent name settings,
// with random gaps on the text side and random stalls on the result side,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------

module crawler_rules_text_parser_core_tb
	import crtp_pkg::*;
();

	localparam int ITEM_GOAL = 1050;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT = 520;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [15:0]            m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	int fail_count;
	int outstanding;
	int bytes_sent = 0;
	bit stall_done = 1'b0;

	// Copy of the programmed agent name, used to build matching agent lines.
	logic [7:0] agent_text [16];
	int         agent_used = 0;

	crawler_rules_text_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	crawler_rules_text_parser_checker rule_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
			@(posedge clk);
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Neither side idles inside this window of the text.
	function automatic bit quiet_window();
		return bytes_sent >= 700 && bytes_sent < 820;
	endfunction

	function automatic string keyword_of(int k);
		case (k)
			0: return "User-agent:";
			1: return "Disallow:";
			2: return "Allow:";
			3: return "Sitemap:";
			default: return "Crawl-delay:";
		endcase
	endfunction

	function automatic logic [7:0] mix_case(logic [7:0] c);
		logic [7:0] low;
		low = c | 8'h20;
		if (low >= "a" && low <= "z" && $urandom_range(1) == 1) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	function automatic logic [127:0] letter_name();
		logic [127:0] n;
		int           i;
		int           r;
		for (i = 0; i < 16; i++) begin
			r = $urandom_range(37);
			if (r < 26) begin
				n[8*i +: 8] = mix_case(8'("a" + r));
			end else if (r < 36) begin
				n[8*i +: 8] = 8'("0" + r - 26);
			end else begin
				n[8*i +: 8] = "-";
			end
		end
		return n;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!quiet_window() && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (s_tready !== 1'b1) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_str(input string s, input bit mixed);
		int         i;
		logic [7:0] c;
		for (i = 0; i < s.len(); i++) begin
			c = s[i];
			send_byte(mixed ? mix_case(c) : c, 1'b0);
		end
	endtask

	task automatic send_blanks(input int most);
		repeat ($urandom_range(most)) begin
			send_byte($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
		end
	endtask

	// Value text: mostly printable, some blanks and some bytes with the top bit set.
	task automatic send_value_text(input int n);
		int         r;
		logic [7:0] c;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 8) begin
				c = $urandom_range(1) ? CH_SPACE : CH_TAB;
			end else if (r < 16) begin
				c = 8'($urandom_range(128, 255));
			end else begin
				do begin
					c = 8'($urandom_range(33, 126));
				end while (c == CH_HASH);
			end
			send_byte(c, 1'b0);
		end
	endtask

	task automatic send_value();
		send_blanks(2);
		send_value_text($urandom_range(8));
		if ($urandom_range(3) == 0) begin
			send_blanks(2);
		end
	endtask

	task automatic send_agent_value();
		int         pick;
		int         n;
		int         i;
		logic [7:0] c;
		pick = $urandom_range(6);
		if (pick == 0) begin
			send_byte(CH_STAR, 1'b0);
			send_value_text($urandom_range(3));
		end else if (pick <= 4) begin
			n = agent_used;
			if (pick == 3 && n > 0) begin
				n = n - 1;
			end
			for (i = 0; i < n; i++) begin
				c = mix_case(agent_text[i]);
				if (pick == 4 && i == n - 1) begin
					c = c ^ 8'h01;
				end
				send_byte(c, 1'b0);
			end
			if (pick == 2) begin
				send_value_text($urandom_range(1, 4));
			end
		end else if (pick == 6) begin
			send_value_text($urandom_range(1, 6));
		end
	endtask

	task automatic send_line_end();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) begin
			send_byte(CH_LF, 1'b0);
		end else if (pick < 7) begin
			send_byte(CH_CR, 1'b0);
			send_byte(CH_LF, 1'b0);
		end else if (pick < 8) begin
			send_byte(CH_CR, 1'b0);
		end else begin
			send_blanks(1);
			send_byte(CH_HASH, 1'b0);
			send_value_text($urandom_range(3));
			send_byte(CH_LF, 1'b0);
		end
	endtask

	task automatic send_random_line(input bit open_end);
		int    pick;
		string w;
		pick = $urandom_range(99);
		send_blanks(1);
		if (pick < 30) begin
			send_str(keyword_of($urandom_range(1, 2)), 1'b1);
			send_value();
		end else if (pick < 45) begin
			send_str(keyword_of(4), 1'b1);
			send_value();
		end else if (pick < 65) begin
			send_str(keyword_of(0), 1'b1);
			send_blanks(2);
			send_agent_value();
		end else if (pick < 73) begin
			send_str(keyword_of(3), 1'b1);
			send_value();
		end else if (pick < 81) begin
			send_byte(CH_HASH, 1'b0);
			send_value_text($urandom_range(6));
		end else if (pick < 87) begin
			send_blanks(2);
		end else if (pick < 93) begin
			// A keyword cut off before its colon.
			w = keyword_of($urandom_range(4));
			send_str(w.substr(0, $urandom_range(w.len() - 2)), 1'b1);
		end else begin
			repeat ($urandom_range(1, 6)) begin
				send_byte(8'($urandom_range(1, 255)), 1'b0);
			end
		end
		if (!open_end) begin
			send_line_end();
		end
	endtask

	task automatic send_random_text();
		int lines;
		int i;
		int pick;
		bit cut;
		lines = $urandom_range(1, 8);
		cut = ($urandom_range(4) == 0);
		for (i = 0; i < lines; i++) begin
			send_random_line(cut && i == lines - 1);
		end
		pick = $urandom_range(9);
		if (pick < 4) begin
			send_byte(CH_NUL, 1'b0);
		end else if (pick < 8) begin
			send_byte(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_agent(input logic [127:0] name, input logic [4:0] len);
		logic [63:0] len_word;
		int          i;
		len_word = {$urandom, $urandom};
		len_word[4:0] = len;
		cfg_we <= 1'b1;
		cfg_index <= REG_NAME_LOW;
		cfg_wdata <= name[63:0];
		@(posedge clk);
		cfg_index <= REG_NAME_HIGH;
		cfg_wdata <= name[127:64];
		@(posedge clk);
		cfg_index <= REG_NAME_LENGTH;
		cfg_wdata <= len_word;
		@(posedge clk);
		// The spare index must leave every register alone.
		cfg_index <= REG_UNUSED;
		cfg_wdata <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
		for (i = 0; i < 16; i++) begin
			agent_text[i] = name[8*i +: 8];
		end
		agent_used = (len > MAX_AGENT_LEN_DEF) ? MAX_AGENT_LEN_DEF : int'(len);
	endtask

	initial begin : result_sink
		int hold_left;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!stall_done && bytes_sent >= HOLD_AT) begin
				stall_done = 1'b1;
				m_tready <= 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
					@(posedge clk);
				end
			end
			m_tready <= quiet_window() || ($urandom_range(99) >= 17);
		end
	end

	initial begin : stimulus
		int phase;
		int goal;
		int i;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_NAME_LOW;
		cfg_wdata <= '0;
		for (i = 0; i < 16; i++) begin
			agent_text[i] = 8'h00;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text under the reset name (length zero accepts every group):
		// empty agent, empty value, blanks and case, trailing blank, comment
		// ending a value, sitemap, partial keyword, close by zero and by tlast.
		send_str("User-agent:\n", 1'b0);
		send_str("Allow:\n", 1'b0);
		send_str(" \tdISALLOW:\t/a \r", 1'b0);
		send_str("Crawl-delay:5#\n", 1'b0);
		send_str("Sitemap: /s\n", 1'b0);
		send_str("Disa\n", 1'b0);
		send_str("Disallow:q", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_str("Allow:z", 1'b0);
		send_byte(8'hff, 1'b1);

		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				1: program_agent(letter_name(), 5'd16);
				2: program_agent(letter_name(), 5'd5);
				3: program_agent(letter_name(), 5'd31);
				4: program_agent(letter_name(), 5'd1);
				5: program_agent({$urandom, $urandom, $urandom, $urandom}, 5'd9);
				6: program_agent(letter_name(), 5'd0);
				default: begin
				end
			endcase
			goal = (ITEM_GOAL * (phase + 1)) / 7;
			while (bytes_sent < goal) begin
				send_random_text();
			end
			settle();
		end

		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
